FILE: sv/vzrd_pkg.sv
package vzrd_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned IDX_W = 10;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CNT_W = 4;

   localparam logic [IDX_W-1:0] SAMPLES_RESET = 10'd299;
   localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = 4'd10;

   localparam logic OP_BASE = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_VARINT_LONG = 2'd1,
      ERR_NO_METRIC  = 2'd2
   } err_type;

   typedef struct packed {
      logic               op;
      logic [BYTE_W-1:0]  stream_byte;
      logic [VALUE_W-1:0] base_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic [IDX_W-1:0]   first_index;
      logic [IDX_W-1:0]   repeat_res;
      logic               metric_done;
      err_type            error;
   } rsp_type;

endpackage

FILE: sv/vzrd_in_reg.sv
module vzrd_in_reg
   import vzrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    take,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_stall = valid_ff && !take;
   assign valid_in = req_stall ? valid_ff : req_valid;
   assign item_valid = valid_ff;
   assign item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: sv/vzrd_core.sv
module vzrd_core
   import vzrd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   input  logic             fire,
   input  req_type          item,
   output logic             res_valid,
   output rsp_type          res
);

   logic [IDX_W-1:0]   samples_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] pending_ff, pending_in;
   logic               run_ff, run_in;
   logic               open_ff, open_in;

   logic [IDX_W-1:0]   len;
   logic [6:0]         shamt;
   logic [VALUE_W-1:0] acc_merged;
   logic [VALUE_W-1:0] delta_sum;
   logic [IDX_W-1:0]   base_take;
   logic [IDX_W-1:0]   avail_m1;
   logic [IDX_W-1:0]   run_take;
   logic [IDX_W-1:0]   run_count;
   logic [IDX_W:0]     pos_after_one;
   logic [IDX_W:0]     pos_after_run;

   always_comb begin
      len = (samples_ff == '0) ? IDX_W'(1) : samples_ff;
      shamt = {3'b000, cnt_ff} * 7'd7;
      acc_merged = acc_ff
         | ({{(VALUE_W-7){1'b0}}, item.stream_byte[6:0]} << shamt[5:0]);
      delta_sum = value_ff + acc_merged;
      base_take = (pending_ff < {{(VALUE_W-IDX_W){1'b0}}, len}) ?
         pending_ff[IDX_W-1:0] : len;
      avail_m1 = len - pos_ff - IDX_W'(1);
      run_take = (acc_merged < {{(VALUE_W-IDX_W){1'b0}}, avail_m1}) ?
         acc_merged[IDX_W-1:0] : avail_m1;
      run_count = run_take + IDX_W'(1);
      pos_after_one = {1'b0, pos_ff} + (IDX_W+1)'(1);
      pos_after_run = {1'b0, pos_ff} + {1'b0, run_count};
   end

   always_comb begin
      value_in = value_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      pending_in = pending_ff;
      run_in = run_ff;
      open_in = open_ff;
      res_valid = 1'b0;
      res = '0;
      res.error = ERR_NONE;
      if (fire) begin
         if (item.op == OP_BASE) begin
            value_in = item.base_value;
            pos_in = '0;
            open_in = 1'b1;
            run_in = 1'b0;
            acc_in = '0;
            cnt_in = '0;
            if (pending_ff != '0) begin
               pending_in = pending_ff - {{(VALUE_W-IDX_W){1'b0}}, base_take};
               pos_in = base_take;
               res_valid = 1'b1;
               res.sample_value = item.base_value;
               res.first_index = IDX_W'(1);
               res.repeat_res = base_take;
               res.metric_done = (base_take == len);
               if (base_take == len) begin
                  open_in = 1'b0;
               end
            end
         end else if (!open_ff || pos_ff >= len) begin
            open_in = 1'b0;
            res_valid = 1'b1;
            res.error = ERR_NO_METRIC;
         end else if (cnt_ff >= VARINT_MAX_BYTES) begin
            acc_in = '0;
            cnt_in = '0;
            res_valid = 1'b1;
            res.error = ERR_VARINT_LONG;
         end else if (item.stream_byte[BYTE_W-1]) begin
            acc_in = acc_merged;
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            acc_in = '0;
            cnt_in = '0;
            if (!run_ff) begin
               if (acc_merged != '0) begin
                  value_in = delta_sum;
                  pos_in = pos_after_one[IDX_W-1:0];
                  res_valid = 1'b1;
                  res.sample_value = delta_sum;
                  res.first_index = pos_after_one[IDX_W-1:0];
                  res.repeat_res = IDX_W'(1);
                  res.metric_done = (pos_after_one >= {1'b0, len});
                  if (pos_after_one >= {1'b0, len}) begin
                     open_in = 1'b0;
                  end
               end else begin
                  run_in = 1'b1;
               end
            end else begin
               run_in = 1'b0;
               pending_in = acc_merged - {{(VALUE_W-IDX_W){1'b0}}, run_take};
               pos_in = pos_after_run[IDX_W-1:0];
               res_valid = 1'b1;
               res.sample_value = value_ff;
               res.first_index = pos_after_one[IDX_W-1:0];
               res.repeat_res = run_count;
               res.metric_done = (pos_after_run >= {1'b0, len});
               if (pos_after_run >= {1'b0, len}) begin
                  open_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= SAMPLES_RESET;
         value_ff <= '0;
         acc_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
         pending_ff <= '0;
         run_ff <= 1'b0;
         open_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            samples_ff <= csr_wr_data;
         end
         value_ff <= value_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         pending_ff <= pending_in;
         run_ff <= run_in;
         open_ff <= open_in;
      end
   end

`ifndef SYNTHESIS
   done_closes_metric: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.metric_done) |=> !open_ff)
      else $error("Metric stayed open after its last sample.");

   base_clears_varint: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == OP_BASE) |=> (cnt_ff == '0 && !run_ff && open_ff == !$past(
         res_valid && res.metric_done)))
      else $error("Base request left varint state behind.");

   good_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.error == ERR_NONE) |-> res.repeat_res != '0)
      else $error("Sample result covers no samples.");

   byte_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= VARINT_MAX_BYTES)
      else $error("Varint byte count ran past its limit.");
`endif

endmodule

FILE: sv/vzrd_out_reg.sv
module vzrd_out_reg
   import vzrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    load_valid,
   input  rsp_type load_data,
   output logic    slot_free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in = load ? load_valid : (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: sv/varint_zero_run_delta_decoder_top.sv
// Decodes metric sample series from a byte stream of little-endian base-128
// varints. A base request opens a metric; each byte request feeds the stream,
// and every completed delta, or zero delta with its run length, yields one
// response carrying the value and how many consecutive samples hold it. The
// block takes one request per cycle while the response side is not stalled,
// and req_stall follows rsp_stall in the same cycle once both registers hold
// data. A taken request goes into the input register, and its response is
// loaded into the response register from there: the decode logic sits between
// the two registers, and its longest path is the varint shift-or followed by
// a 64-bit compare and subtract for the zero run. csr_wr_data sets the samples
// per metric (zero counts as one) and should be written only while the block
// is idle.
module varint_zero_run_delta_decoder_top
   import vzrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [IDX_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [BYTE_W-1:0]  req_stream_byte,
   input  logic [VALUE_W-1:0] req_base_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_sample_value,
   output logic [IDX_W-1:0]   rsp_first_index,
   output logic [IDX_W-1:0]   rsp_repeat_res,
   output logic               rsp_metric_done,
   output logic [1:0]         rsp_error
);

   req_type req_item;
   req_type item;
   logic    item_valid;
   logic    slot_free;
   logic    fire;
   logic    res_valid;
   rsp_type res;
   rsp_type rsp_data;

   assign req_item.op = req_op;
   assign req_item.stream_byte = req_stream_byte;
   assign req_item.base_value = req_base_value;
   assign fire = item_valid && slot_free;

   vzrd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   vzrd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   vzrd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (slot_free),
      .load_valid (fire && res_valid),
      .load_data  (res),
      .slot_free  (slot_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_sample_value = rsp_data.sample_value;
   assign rsp_first_index = rsp_data.first_index;
   assign rsp_repeat_res = rsp_data.repeat_res;
   assign rsp_metric_done = rsp_data.metric_done;
   assign rsp_error = rsp_data.error;

endmodule
